>>> rtl/core/consensus_formation_agent_controller_assert.svh
// Assertion macros for the consensus / formation agent controller.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef CONSENSUS_FORMATION_AGENT_CONTROLLER_ASSERT_SVH
`define CONSENSUS_FORMATION_AGENT_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
`define CFAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CFAC_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define CFAC_ASSERT(lbl, prop, msg)
`define CFAC_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

>>> rtl/core/cfac_pkg.sv
// Shared types and constants of the consensus / formation agent controller.
// No dependencies.
package cfac_pkg;

  localparam int NEIGHBORS_DEF  = 16;
  localparam int COORD_BITS_DEF = 32;
  localparam int CFG_DATA_W     = 64;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CFG_CONTROL_MODE     = 3'd0;
  localparam cfg_idx_t CFG_ADJACENCY_MASK   = 3'd1;
  localparam cfg_idx_t CFG_GAIN_SET         = 3'd2;
  localparam cfg_idx_t CFG_MAX_SPEED        = 3'd3;
  localparam cfg_idx_t CFG_FORMATION_OFFSET = 3'd4;
  localparam cfg_idx_t CFG_LEADER_POSITION  = 3'd5;
  localparam cfg_idx_t CFG_LEADER_VELOCITY  = 3'd6;

  typedef enum logic [1:0] {
    FUNC_REPORT = 2'd0,
    FUNC_UPDATE = 2'd1,
    FUNC_LOAD   = 2'd2
  } func_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [3:0]         neighbor_id;
    logic signed [31:0] pos_x_in;
    logic signed [31:0] pos_y_in;
    logic signed [31:0] vel_x_in;
    logic signed [31:0] vel_y_in;
    logic [15:0]        elapsed;
    logic               hold_control;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] msg_pos_x;
    logic signed [31:0] msg_pos_y;
    logic signed [31:0] own_pos_x;
    logic signed [31:0] own_pos_y;
    logic signed [31:0] own_vel_x;
    logic signed [31:0] own_vel_y;
    logic               speed_limited;
  } out_word_t;

  typedef struct packed {
    logic wr_pos;
    logic wr_vel;
    logic rd;
  } tbl_ctl_t;

endpackage

>>> rtl/core/cfac_nbr_table.sv
// Neighbor position / velocity table: two synchronous RAMs with registered read.
// Per-entry valid bits make unwritten entries read as zero. Uses cfac_pkg.
module cfac_nbr_table #(
  parameter int NEIGHBORS  = cfac_pkg::NEIGHBORS_DEF,
  parameter int COORD_BITS = cfac_pkg::COORD_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfac_pkg::tbl_ctl_t        ctl_i,
  input  logic [$clog2(NEIGHBORS)-1:0] waddr_i,
  input  logic [$clog2(NEIGHBORS)-1:0] raddr_i,
  input  logic [2*COORD_BITS-1:0]   wpos_i,
  input  logic [2*COORD_BITS-1:0]   wvel_i,
  output logic [2*COORD_BITS-1:0]   rpos_o,
  output logic [2*COORD_BITS-1:0]   rvel_o
);

  localparam int RW = 2 * COORD_BITS;

  logic [RW-1:0]        pos_mem [NEIGHBORS];
  logic [RW-1:0]        vel_mem [NEIGHBORS];
  logic [NEIGHBORS-1:0] pos_vld_q;
  logic [NEIGHBORS-1:0] vel_vld_q;
  logic [RW-1:0]        pos_rd_q;
  logic [RW-1:0]        vel_rd_q;
  logic                 pos_rv_q;
  logic                 vel_rv_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_pos) begin
      pos_mem[waddr_i] <= wpos_i;
    end
    if (ctl_i.wr_vel) begin
      vel_mem[waddr_i] <= wvel_i;
    end
    if (ctl_i.rd) begin
      pos_rd_q <= pos_mem[raddr_i];
      vel_rd_q <= vel_mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_vld_q <= '0;
      vel_vld_q <= '0;
      pos_rv_q  <= 1'b0;
      vel_rv_q  <= 1'b0;
    end else begin
      if (ctl_i.wr_pos) begin
        pos_vld_q[waddr_i] <= 1'b1;
      end
      if (ctl_i.wr_vel) begin
        vel_vld_q[waddr_i] <= 1'b1;
      end
      if (ctl_i.rd) begin
        pos_rv_q <= pos_vld_q[raddr_i];
        vel_rv_q <= vel_vld_q[raddr_i];
      end
    end
  end

  assign rpos_o = pos_rv_q ? pos_rd_q : '0;
  assign rvel_o = vel_rv_q ? vel_rd_q : '0;

endmodule

>>> rtl/core/cfac_sqrt.sv
// Integer square root of a 64-bit value, one result bit per step, 32 steps.
// Standalone; no package use.
module cfac_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q;
  logic        done_q;
  logic [63:0] x_q;
  logic [63:0] r_q;
  logic [63:0] bit_q;
  logic [63:0] rb;

  assign rb = r_q + bit_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      r_q   <= '0;
      bit_q <= 64'd1 << 62;
    end else if (busy_q) begin
      if (x_q >= rb) begin
        x_q <= x_q - rb;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q == 64'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[31:0];

endmodule

>>> rtl/core/cfac_div.sv
// Restoring divider: 63-bit dividend by 32-bit divisor, one bit per cycle.
// Quotient is known to fit 32 bits. Standalone; no package use.
module cfac_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [62:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o
);

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [31:0] rem_q;
  logic [62:0] quo_q;
  logic [31:0] den_q;
  logic [32:0] trial;
  logic        fits;

  assign trial = {rem_q, quo_q[62]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
      quo_q <= {quo_q[61:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd62;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q[31:0];

endmodule

>>> rtl/core/consensus_formation_agent_controller.sv
// Agent controller for consensus / formation groups, Q16.16 fixed point.
// Uses cfac_pkg, cfac_nbr_table, cfac_sqrt, cfac_div and the assert header.
//
// One word at a time. A report word writes the neighbor table and gives no
// result. A load word goes straight to the output state, which registers
// its result. An update word walks min(NEIGHBORS,16) table entries, one RAM
// read per cycle, adds leader terms in second-order formation mode, then
// integrates and checks the speed; with hold_control it skips to the
// integration. When the speed must be limited, the shared square root unit
// and the two bit-serial dividers scale the velocity. A finished result
// waits in the output register while the next word is accepted.
`include "consensus_formation_agent_controller_assert.svh"
module consensus_formation_agent_controller #(
  parameter int NEIGHBORS  = cfac_pkg::NEIGHBORS_DEF,
  parameter int COORD_BITS = cfac_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  cfac_pkg::cfg_idx_t            cfg_idx_i,
  input  logic [cfac_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  cfac_pkg::in_word_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cfac_pkg::out_word_t           out_data_o
);

  localparam int CB   = COORD_BITS;
  localparam int AW   = $clog2(NEIGHBORS);
  localparam int WALK = (NEIGHBORS < 16) ? NEIGHBORS : 16;
  localparam int CW   = $clog2(WALK + 1);
  localparam logic [CW-1:0] WALK_C = CW'(WALK);
  localparam logic signed [63:0] CMAX = (64'sd1 <<< (CB - 1)) - 64'sd1;
  localparam logic signed [63:0] CMIN = -(64'sd1 <<< (CB - 1));
  localparam logic signed [33:0] M32MAX = 34'sd2147483647;
  localparam logic signed [33:0] M32MIN = -34'sd2147483648;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_SUM   = 12'b0000_0000_0010,
    ST_FORM1 = 12'b0000_0000_0100,
    ST_FORM2 = 12'b0000_0000_1000,
    ST_INT1  = 12'b0000_0001_0000,
    ST_INT2  = 12'b0000_0010_0000,
    ST_MAG1  = 12'b0000_0100_0000,
    ST_MAG2  = 12'b0000_1000_0000,
    ST_SQRT  = 12'b0001_0000_0000,
    ST_DPROD = 12'b0010_0000_0000,
    ST_DIV   = 12'b0100_0000_0000,
    ST_OUT   = 12'b1000_0000_0000
  } state_e;

  function automatic logic signed [CB-1:0] sat_c(input logic signed [63:0] v);
    logic signed [CB-1:0] r;
    if (v > CMAX) begin
      r = CMAX[CB-1:0];
    end else if (v < CMIN) begin
      r = CMIN[CB-1:0];
    end else begin
      r = v[CB-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > M32MAX) begin
      r = M32MAX[31:0];
    end else if (v < M32MIN) begin
      r = M32MIN[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // configuration
  logic [1:0]  mode_q;
  logic [15:0] mask_q;
  logic [63:0] gain_q;
  logic [30:0] maxspd_q;
  logic [63:0] off_q;
  logic [63:0] lp_q;
  logic [63:0] lv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= '0;
      mask_q   <= '0;
      gain_q   <= '0;
      maxspd_q <= '0;
      off_q    <= '0;
      lp_q     <= '0;
      lv_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cfac_pkg::CFG_CONTROL_MODE:     mode_q   <= cfg_data_i[1:0];
        cfac_pkg::CFG_ADJACENCY_MASK:   mask_q   <= cfg_data_i[15:0];
        cfac_pkg::CFG_GAIN_SET:         gain_q   <= cfg_data_i;
        cfac_pkg::CFG_MAX_SPEED:        maxspd_q <= cfg_data_i[30:0];
        cfac_pkg::CFG_FORMATION_OFFSET: off_q    <= cfg_data_i;
        cfac_pkg::CFG_LEADER_POSITION:  lp_q     <= cfg_data_i;
        cfac_pkg::CFG_LEADER_VELOCITY:  lv_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic        formation;
  logic        second;
  logic [15:0] g_gamma;
  logic [15:0] g_c;
  logic [15:0] g_kp;
  logic [15:0] g_kv;

  assign formation = mode_q[0];
  assign second    = mode_q[1];
  assign g_gamma   = gain_q[15:0];
  assign g_c       = gain_q[31:16];
  assign g_kp      = gain_q[47:32];
  assign g_kv      = gain_q[63:48];

  // state and datapath registers
  state_e state_q, state_d;
  logic signed [CB-1:0] p_q [2];
  logic signed [CB-1:0] p_d [2];
  logic signed [CB-1:0] v_q [2];
  logic signed [CB-1:0] v_d [2];
  logic signed [CB-1:0] u_q [2];
  logic signed [CB-1:0] u_d [2];
  logic signed [47:0]   acc_q [2];
  logic signed [47:0]   acc_d [2];
  logic signed [63:0]   cs_q [2];
  logic signed [63:0]   cs_d [2];
  logic signed [57:0]   lvp_q [2];
  logic signed [57:0]   lvp_d [2];
  logic signed [50:0]   kpp_q [2];
  logic signed [50:0]   kpp_d [2];
  logic signed [CB+16:0] pv_q [2];
  logic signed [CB+16:0] pv_d [2];
  logic signed [CB+16:0] ud_q [2];
  logic signed [CB+16:0] ud_d [2];
  logic [2*CB-1:0]      sq_q [2];
  logic [2*CB-1:0]      sq_d [2];
  logic [61:0]          lim_q, lim_d;
  logic [15:0]          dt_q, dt_d;
  logic [23:0]          gk_q, gk_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 pend_q, pend_d;
  logic [3:0]           pidx_q, pidx_d;
  logic                 limited_q, limited_d;
  logic                 out_valid_q, out_valid_d;
  cfac_pkg::out_word_t  out_q, out_d;

  // table
  cfac_pkg::tbl_ctl_t   tbl_ctl;
  logic [AW-1:0]        tbl_waddr;
  logic [AW-1:0]        tbl_raddr;
  logic [2*CB-1:0]      tbl_wpos;
  logic [2*CB-1:0]      tbl_wvel;
  logic [2*CB-1:0]      tbl_rpos;
  logic [2*CB-1:0]      tbl_rvel;
  logic [AW+3:0]        id_ext;

  cfac_nbr_table #(
    .NEIGHBORS (NEIGHBORS),
    .COORD_BITS(COORD_BITS)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (tbl_ctl),
    .waddr_i(tbl_waddr),
    .raddr_i(tbl_raddr),
    .wpos_i (tbl_wpos),
    .wvel_i (tbl_wvel),
    .rpos_o (tbl_rpos),
    .rvel_o (tbl_rvel)
  );

  // square root and dividers
  logic        sqrt_start;
  logic [63:0] sqrt_x;
  logic        sqrt_done;
  logic [31:0] sqrt_root;
  logic        div_start;
  logic [62:0] div_num [2];
  logic [1:0]  div_done;
  logic [31:0] div_quo [2];

  cfac_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sqrt_start),
    .x_i    (sqrt_x),
    .done_o (sqrt_done),
    .root_o (sqrt_root)
  );

  for (genvar g = 0; g < 2; g++) begin : g_div
    cfac_div u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .start_i(div_start),
      .num_i  (div_num[g]),
      .den_i  (sqrt_root),
      .done_o (div_done[g]),
      .quo_o  (div_quo[g])
    );
  end

  // combinational helpers
  logic                 accept;
  logic signed [31:0]   offs [2];
  logic signed [31:0]   lps [2];
  logic signed [31:0]   lvs [2];
  logic signed [CB-1:0] pj [2];
  logic signed [CB-1:0] vj [2];
  logic signed [33:0]   d1 [2];
  logic signed [32:0]   dv [2];
  logic signed [49:0]   gdv [2];
  logic signed [47:0]   term [2];
  logic signed [32:0]   lvd [2];
  logic signed [33:0]   lpo [2];
  logic signed [CB:0]   vw [2];
  logic signed [CB:0]   av [2];
  logic signed [32:0]   qs [2];
  logic signed [CB-1:0] in_p [2];
  logic signed [CB-1:0] in_v [2];
  logic [63:0]          mag;
  logic                 rd_go;

  assign accept = in_valid_i && in_ready_o;
  assign id_ext = {{AW{1'b0}}, in_data_i.neighbor_id};
  assign mag    = 64'(sq_q[0]) + 64'(sq_q[1]);
  assign sqrt_x = mag;

  always_comb begin
    in_p[0] = sat_c(64'(in_data_i.pos_x_in));
    in_p[1] = sat_c(64'(in_data_i.pos_y_in));
    in_v[0] = sat_c(64'(in_data_i.vel_x_in));
    in_v[1] = sat_c(64'(in_data_i.vel_y_in));
    for (int a = 0; a < 2; a++) begin
      offs[a] = formation ? $signed(off_q[32*a +: 32]) : 32'sd0;
      lps[a]  = $signed(lp_q[32*a +: 32]);
      lvs[a]  = $signed(lv_q[32*a +: 32]);
      pj[a]   = $signed(tbl_rpos[CB*a +: CB]);
      vj[a]   = $signed(tbl_rvel[CB*a +: CB]);
      d1[a]   = 34'(p_q[a]) - 34'(offs[a]) - 34'(pj[a]);
      dv[a]   = 33'(v_q[a]) - 33'(vj[a]);
      gdv[a]  = $signed({1'b0, g_gamma}) * dv[a];
      term[a] = 48'(d1[a]) + (second ? 48'(gdv[a] >>> 8) : 48'sd0);
      lvd[a]  = 33'(lvs[a]) - 33'(v_q[a]);
      lpo[a]  = 34'(lps[a]) + 34'(offs[a]) - 34'(p_q[a]);
      vw[a]   = (CB+1)'(v_q[a]);
      av[a]   = (vw[a] < 0) ? -vw[a] : vw[a];
      div_num[a] = 63'(av[a][CB-1:0]) * 63'(maxspd_q);
      qs[a]   = $signed({1'b0, div_quo[a]});
    end
  end

  always_comb begin
    state_d     = state_q;
    p_d         = p_q;
    v_d         = v_q;
    u_d         = u_q;
    acc_d       = acc_q;
    cs_d        = cs_q;
    lvp_d       = lvp_q;
    kpp_d       = kpp_q;
    pv_d        = pv_q;
    ud_d        = ud_q;
    sq_d        = sq_q;
    lim_d       = lim_q;
    dt_d        = dt_q;
    gk_d        = gk_q;
    cnt_d       = cnt_q;
    pend_d      = 1'b0;
    pidx_d      = pidx_q;
    limited_d   = limited_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    tbl_ctl     = '0;
    tbl_waddr   = id_ext[AW-1:0];
    tbl_raddr   = AW'(cnt_q);
    tbl_wpos    = {in_p[1], in_p[0]};
    tbl_wvel    = {in_v[1], in_v[0]};
    sqrt_start  = 1'b0;
    div_start   = 1'b0;
    rd_go       = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          dt_d  = in_data_i.elapsed;
          gk_d  = 24'((32'(g_gamma) * 32'(g_kv)) >> 8);
          cnt_d = '0;
          acc_d[0] = '0;
          acc_d[1] = '0;
          if (in_data_i.func == cfac_pkg::FUNC_REPORT) begin
            if (32'(in_data_i.neighbor_id) < NEIGHBORS) begin
              tbl_ctl.wr_pos = 1'b1;
              tbl_ctl.wr_vel = second;
            end
          end else if (in_data_i.func == cfac_pkg::FUNC_LOAD) begin
            p_d       = in_p;
            v_d       = in_v;
            limited_d = 1'b0;
            state_d   = ST_OUT;
          end else if (in_data_i.func == cfac_pkg::FUNC_UPDATE) begin
            state_d = in_data_i.hold_control ? ST_INT1 : ST_SUM;
          end
        end
      end
      ST_SUM: begin
        rd_go       = cnt_q < WALK_C;
        tbl_ctl.rd  = rd_go;
        pend_d      = rd_go;
        if (rd_go) begin
          cnt_d  = cnt_q + CW'(1);
          pidx_d = 4'(cnt_q);
        end
        if (pend_q && mask_q[pidx_q]) begin
          acc_d[0] = acc_q[0] + term[0];
          acc_d[1] = acc_q[1] + term[1];
        end
        if (!rd_go && !pend_q) begin
          if (second && formation) begin
            state_d = ST_FORM1;
          end else begin
            u_d[0]  = sat_c(64'(acc_q[0]));
            u_d[1]  = sat_c(64'(acc_q[1]));
            state_d = ST_INT1;
          end
        end
      end
      ST_FORM1: begin
        for (int a = 0; a < 2; a++) begin
          cs_d[a]  = $signed({1'b0, g_c}) * acc_q[a];
          lvp_d[a] = $signed({1'b0, gk_q}) * lvd[a];
          kpp_d[a] = $signed({1'b0, g_kp}) * lpo[a];
        end
        state_d = ST_FORM2;
      end
      ST_FORM2: begin
        for (int a = 0; a < 2; a++) begin
          u_d[a] = sat_c((cs_q[a] >>> 8) - 64'(lvp_q[a] >>> 8) - 64'(kpp_q[a] >>> 8));
        end
        state_d = ST_INT1;
      end
      ST_INT1: begin
        for (int a = 0; a < 2; a++) begin
          pv_d[a] = v_q[a] * $signed({1'b0, dt_q});
          ud_d[a] = u_q[a] * $signed({1'b0, dt_q});
        end
        state_d = ST_INT2;
      end
      ST_INT2: begin
        for (int a = 0; a < 2; a++) begin
          p_d[a] = sat_c(64'(p_q[a]) + 64'(pv_q[a] >>> 16));
          v_d[a] = second ? sat_c(64'(v_q[a]) - 64'(ud_q[a] >>> 16))
                          : sat_c(-64'(u_q[a]));
        end
        state_d = ST_MAG1;
      end
      ST_MAG1: begin
        sq_d[0] = v_q[0] * v_q[0];
        sq_d[1] = v_q[1] * v_q[1];
        lim_d   = maxspd_q * maxspd_q;
        state_d = ST_MAG2;
      end
      ST_MAG2: begin
        if (mag > 64'(lim_q)) begin
          sqrt_start = 1'b1;
          limited_d  = 1'b1;
          state_d    = ST_SQRT;
        end else begin
          limited_d = 1'b0;
          state_d   = ST_OUT;
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          state_d = ST_DPROD;
        end
      end
      ST_DPROD: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done[0]) begin
          for (int a = 0; a < 2; a++) begin
            v_d[a] = (v_q[a] < 0) ? CB'(-qs[a]) : CB'(qs[a]);
          end
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d             = 1'b1;
          out_d.msg_pos_x         = clamp32(34'(p_q[0]) - 34'(offs[0]));
          out_d.msg_pos_y         = clamp32(34'(p_q[1]) - 34'(offs[1]));
          out_d.own_pos_x         = 32'(p_q[0]);
          out_d.own_pos_y         = 32'(p_q[1]);
          out_d.own_vel_x         = 32'(v_q[0]);
          out_d.own_vel_y         = 32'(v_q[1]);
          out_d.speed_limited     = limited_q;
          state_d                 = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      cnt_q       <= '0;
      limited_q   <= 1'b0;
      for (int a = 0; a < 2; a++) begin
        p_q[a] <= '0;
        v_q[a] <= '0;
        u_q[a] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      limited_q   <= limited_d;
      p_q         <= p_d;
      v_q         <= v_d;
      u_q         <= u_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    cs_q   <= cs_d;
    lvp_q  <= lvp_d;
    kpp_q  <= kpp_d;
    pv_q   <= pv_d;
    ud_q   <= ud_d;
    sq_q   <= sq_d;
    lim_q  <= lim_d;
    dt_q   <= dt_d;
    gk_q   <= gk_d;
    pidx_q <= pidx_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CFAC_ASSERT(a_sqrt_done_state, sqrt_done |-> state_q == ST_SQRT, "sqrt done outside wait")
  `CFAC_ASSERT(a_div_lockstep, div_done[0] == div_done[1], "dividers out of step")
  `CFAC_ASSERT_NEVER(a_tbl_wr_busy, tbl_ctl.wr_pos && state_q != ST_IDLE, "table write while busy")
  `CFAC_ASSERT(a_hold_skips_sum, accept && in_data_i.func == cfac_pkg::FUNC_UPDATE && in_data_i.hold_control |=> state_q == ST_INT1, "hold did not skip sum")

endmodule
